>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL, all clocked on clock and
// switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge
`define ASSERT_NOW(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("invariant violated");

// Condition that must hold in the same cycle as its trigger
`define ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication violated");

// Condition that must hold in the cycle after its trigger
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sequence violated");

`endif

>>> sv/alle_pkg.sv
`timescale 1ns / 1ps

package alle_pkg;

   // defaults and fixed port widths
   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int VALUE_W        = 32;
   localparam int SLOT_PORT_W    = 6;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic {
      REQ_APPEND = 1'b0,
      REQ_DELETE = 1'b1
   } req_kind_type;

   // microcode addresses
   typedef logic [2:0] upc_type;
   localparam upc_type UPC_IDLE       = 3'd0;
   localparam upc_type UPC_CHECK      = 3'd1;
   localparam upc_type UPC_APP_LINK   = 3'd2;
   localparam upc_type UPC_APP_CLOSE  = 3'd3;
   localparam upc_type UPC_DEL_UNLINK = 3'd4;
   localparam upc_type UPC_DEL_PUSH   = 3'd5;
   localparam upc_type UPC_REJECT     = 3'd6;

   // sequencing: step on, wait for start, dispatch on request, jump
   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_WAIT,
      SEQ_DISPATCH,
      SEQ_JUMP
   } seq_type;

   // next-link write: tail->slot, slot->0, prev->next, slot->free head
   typedef enum logic [2:0] {
      NWR_NONE,
      NWR_TAIL_LINK,
      NWR_SLOT_CLR,
      NWR_PREV_LINK,
      NWR_SLOT_FREE
   } nwr_type;

   // prev-link write: slot<-tail, next<-prev, slot<-0
   typedef enum logic [1:0] {
      PWR_NONE,
      PWR_SLOT_TAIL,
      PWR_NEXT_LINK,
      PWR_SLOT_CLR
   } pwr_type;

   typedef enum logic [1:0] {
      FWR_NONE,
      FWR_CLR,
      FWR_SET
   } fwr_type;

   // list register update
   typedef enum logic [1:0] {
      LST_NONE,
      LST_APPEND,
      LST_UNLINK,
      LST_PUSH
   } lst_type;

   typedef struct packed {
      seq_type seq;
      upc_type target;
      logic    ld_rd;
      nwr_type nwr;
      pwr_type pwr;
      fwr_type fwr;
      logic    val_we;
      lst_type lst;
      logic    respond;
   } ucode_type;

   // control store
   function automatic ucode_type ucode_rom(input upc_type upc);
      ucode_type w;
      w = '{seq: SEQ_JUMP, target: UPC_IDLE, ld_rd: 1'b0, nwr: NWR_NONE,
            pwr: PWR_NONE, fwr: FWR_NONE, val_we: 1'b0, lst: LST_NONE,
            respond: 1'b0};
      case (upc)
         UPC_IDLE: begin
            w.seq    = SEQ_WAIT;
            w.target = UPC_IDLE;
         end
         UPC_CHECK: begin
            w.seq    = SEQ_DISPATCH;
            w.target = UPC_REJECT;
            w.ld_rd  = 1'b1;
         end
         UPC_APP_LINK: begin
            w.seq    = SEQ_NEXT;
            w.nwr    = NWR_TAIL_LINK;
            w.pwr    = PWR_SLOT_TAIL;
            w.fwr    = FWR_CLR;
            w.val_we = 1'b1;
            w.lst    = LST_APPEND;
         end
         UPC_APP_CLOSE: begin
            w.nwr     = NWR_SLOT_CLR;
            w.respond = 1'b1;
         end
         UPC_DEL_UNLINK: begin
            w.seq = SEQ_NEXT;
            w.nwr = NWR_PREV_LINK;
            w.pwr = PWR_NEXT_LINK;
            w.fwr = FWR_SET;
            w.lst = LST_UNLINK;
         end
         UPC_DEL_PUSH: begin
            w.nwr     = NWR_SLOT_FREE;
            w.pwr     = PWR_SLOT_CLR;
            w.lst     = LST_PUSH;
            w.respond = 1'b1;
         end
         UPC_REJECT: begin
            w.respond = 1'b1;
         end
         default: begin
            w.target = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> sv/alle_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module alle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/array_linked_list_engine_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Linked-list engine: a request beat is taken when start is high and busy is
// low; busy stays high until its result has been loaded. No new request is
// taken until the last is through: an append or a delete runs three microcode
// steps after the accept, a rejected request (list full, bad or free slot)
// only the check and reject steps. The microcode program sets this: one read
// of the link memories, then two steps because the next-link memory takes one
// write per cycle. The result beat appears on the rsp_ ports in the cycle
// after the last step, with rsp_valid high for a single cycle; the receiver
// cannot stall, so it must capture every beat that rsp_valid marks. A new
// request may be accepted in the cycle that a result is shown. No clearing
// pass runs after reset: a fill mark stands in for the reset contents of
// slots never used, so the block is ready in the first cycle after reset.
module array_linked_list_engine_core
   import alle_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_type,
   input  logic [VALUE_W-1:0]     req_value,
   input  logic [SLOT_PORT_W-1:0] req_position,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [SLOT_PORT_W-1:0] rsp_slot,
   output logic [VALUE_W-1:0]     rsp_removed_value,
   output logic [SLOT_PORT_W-1:0] rsp_head_slot,
   output logic [SLOT_PORT_W-1:0] rsp_tail_slot,
   output logic [SLOT_PORT_W-1:0] rsp_entry_count
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CMP_W  = ((SLOT_W > SLOT_PORT_W) ? SLOT_W : SLOT_PORT_W) + 1;

   typedef logic [SLOT_W-1:0] slot_type;

   // sequencer
   upc_type   upc_ff, upc_in;
   ucode_type uw;

   // request latched at accept
   req_kind_type        kind_ff, kind_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   slot_type            slot_ff, slot_in;
   logic                pos_bad_ff, pos_bad_in;
   logic                fresh_ff, fresh_in;

   // list registers
   slot_type            fh_ff, fh_in;
   slot_type            first_ff, first_in;
   slot_type            last_ff, last_in;
   slot_type            count_ff, count_in;
   logic [SLOT_W:0]     fill_ff, fill_in;

   // read data after fill correction
   slot_type            n_ff, n_in;
   slot_type            p_ff, p_in;
   logic [DATA_WIDTH-1:0] rval_ff, rval_in;
   status_type          status_ff, status_in;

   // result beat
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   slot_type            rsp_slot_ff, rsp_slot_in;
   logic [DATA_WIDTH-1:0] rsp_rval_ff, rsp_rval_in;
   slot_type            rsp_head_ff, rsp_head_in;
   slot_type            rsp_tail_ff, rsp_tail_in;
   slot_type            rsp_count_ff, rsp_count_in;

   // memory ports
   slot_type            rd_addr;
   logic                nxt_we, prv_we, fre_we;
   slot_type            nxt_waddr, prv_waddr;
   slot_type            nxt_wdata, prv_wdata;
   logic                fre_wdata;
   slot_type            nxt_q, prv_q;
   logic                fre_q;
   logic [DATA_WIDTH-1:0] val_q;

   slot_type            n_eff, p_eff;
   logic                free_eff;
   logic                accept, reject;

   assign uw     = ucode_rom(upc_ff);
   assign busy   = (upc_ff != UPC_IDLE);
   assign accept = start && !busy;

   // one read address for all memories: the request position for a delete, else the free head
   assign rd_addr = (req_type == REQ_DELETE) ? slot_type'(req_position) : fh_ff;

   alle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next_ram (
      .clock  (clock),
      .wr_en  (nxt_we),
      .wr_addr(nxt_waddr),
      .wr_data(nxt_wdata),
      .rd_addr(rd_addr),
      .rd_data(nxt_q)
   );

   alle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev_ram (
      .clock  (clock),
      .wr_en  (prv_we),
      .wr_addr(prv_waddr),
      .wr_data(prv_wdata),
      .rd_addr(rd_addr),
      .rd_data(prv_q)
   );

   alle_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_free_ram (
      .clock  (clock),
      .wr_en  (fre_we),
      .wr_addr(slot_ff),
      .wr_data(fre_wdata),
      .rd_addr(rd_addr),
      .rd_data(fre_q)
   );

   alle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
      .clock  (clock),
      .wr_en  (uw.val_we),
      .wr_addr(slot_ff),
      .wr_data(value_ff),
      .rd_addr(rd_addr),
      .rd_data(val_q)
   );

   // slots at or beyond the fill mark still hold their reset links
   always_comb begin
      if (fresh_ff) begin
         n_eff    = (slot_ff == slot_type'(CAPACITY - 1)) ? '0 : slot_ff + 1'b1;
         p_eff    = '0;
         free_eff = 1'b1;
      end else begin
         n_eff    = nxt_q;
         p_eff    = prv_q;
         free_eff = fre_q;
      end
   end

   assign reject = (kind_ff == REQ_DELETE) ? (pos_bad_ff || free_eff) : (fh_ff == '0);

   // memory write selection
   always_comb begin
      nxt_we    = 1'b0;
      nxt_waddr = slot_ff;
      nxt_wdata = '0;
      case (uw.nwr)
         NWR_TAIL_LINK: begin
            nxt_we    = (last_ff != '0);
            nxt_waddr = last_ff;
            nxt_wdata = slot_ff;
         end
         NWR_SLOT_CLR: begin
            nxt_we = 1'b1;
         end
         NWR_PREV_LINK: begin
            nxt_we    = (p_ff != '0);
            nxt_waddr = p_ff;
            nxt_wdata = n_ff;
         end
         NWR_SLOT_FREE: begin
            nxt_we    = 1'b1;
            nxt_wdata = fh_ff;
         end
         default: begin
            nxt_we = 1'b0;
         end
      endcase

      prv_we    = 1'b0;
      prv_waddr = slot_ff;
      prv_wdata = '0;
      case (uw.pwr)
         PWR_SLOT_TAIL: begin
            prv_we    = 1'b1;
            prv_wdata = last_ff;
         end
         PWR_NEXT_LINK: begin
            prv_we    = (n_ff != '0);
            prv_waddr = n_ff;
            prv_wdata = p_ff;
         end
         PWR_SLOT_CLR: begin
            prv_we = 1'b1;
         end
         default: begin
            prv_we = 1'b0;
         end
      endcase

      case (uw.fwr)
         FWR_CLR: begin
            fre_we    = 1'b1;
            fre_wdata = 1'b0;
         end
         FWR_SET: begin
            fre_we    = 1'b1;
            fre_wdata = 1'b1;
         end
         default: begin
            fre_we    = 1'b0;
            fre_wdata = 1'b0;
         end
      endcase
   end

   // step counter and datapath next values
   always_comb begin
      upc_in = upc_ff + 1'b1;
      case (uw.seq)
         SEQ_WAIT: begin
            upc_in = start ? upc_ff + 1'b1 : uw.target;
         end
         SEQ_DISPATCH: begin
            if (reject) begin
               upc_in = uw.target;
            end else if (kind_ff == REQ_DELETE) begin
               upc_in = UPC_DEL_UNLINK;
            end else begin
               upc_in = upc_ff + 1'b1;
            end
         end
         SEQ_JUMP: begin
            upc_in = uw.target;
         end
         default: begin
            upc_in = upc_ff + 1'b1;
         end
      endcase

      // request capture
      kind_in    = kind_ff;
      value_in   = value_ff;
      slot_in    = slot_ff;
      pos_bad_in = pos_bad_ff;
      fresh_in   = fresh_ff;
      if (accept) begin
         kind_in    = req_kind_type'(req_type);
         value_in   = DATA_WIDTH'(req_value);
         slot_in    = rd_addr;
         pos_bad_in = (req_position == '0) ||
                      (CMP_W'(req_position) >= CMP_W'(CAPACITY));
         fresh_in   = ({1'b0, rd_addr} >= fill_ff);
      end

      // read data capture and status
      n_in      = n_ff;
      p_in      = p_ff;
      rval_in   = rval_ff;
      status_in = status_ff;
      if (uw.ld_rd) begin
         n_in    = n_eff;
         p_in    = p_eff;
         rval_in = val_q;
         if (!reject) begin
            status_in = ST_DONE;
         end else if (kind_ff == REQ_DELETE) begin
            status_in = ST_BAD;
         end else begin
            status_in = ST_FULL;
         end
      end

      // list registers
      fh_in    = fh_ff;
      first_in = first_ff;
      last_in  = last_ff;
      count_in = count_ff;
      fill_in  = fill_ff;
      case (uw.lst)
         LST_APPEND: begin
            fh_in    = n_ff;
            last_in  = slot_ff;
            count_in = count_ff + 1'b1;
            if (count_ff == '0) begin
               first_in = slot_ff;
            end
            if (fresh_ff) begin
               fill_in = fill_ff + 1'b1;
            end
         end
         LST_UNLINK: begin
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
            if (first_ff == slot_ff) begin
               first_in = n_ff;
            end
            if (last_ff == slot_ff) begin
               last_in = p_ff;
            end
         end
         LST_PUSH: begin
            fh_in = slot_ff;
         end
         default: begin
            fh_in = fh_ff;
         end
      endcase

      // result beat
      rsp_valid_in  = uw.respond;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_rval_in   = rsp_rval_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_tail_in   = rsp_tail_ff;
      rsp_count_in  = rsp_count_ff;
      if (uw.respond) begin
         rsp_status_in = status_ff;
         rsp_slot_in   = (status_ff == ST_DONE) ? slot_ff : '0;
         rsp_rval_in   = (status_ff == ST_DONE && kind_ff == REQ_DELETE) ? rval_ff : '0;
         rsp_head_in   = first_ff;
         rsp_tail_in   = last_ff;
         rsp_count_in  = count_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_IDLE;
         fh_ff        <= slot_type'(1);
         first_ff     <= '0;
         last_ff      <= '0;
         count_ff     <= '0;
         fill_ff      <= (SLOT_W + 1)'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         fh_ff        <= fh_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      slot_ff       <= slot_in;
      pos_bad_ff    <= pos_bad_in;
      fresh_ff      <= fresh_in;
      n_ff          <= n_in;
      p_ff          <= p_in;
      rval_ff       <= rval_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_rval_ff   <= rsp_rval_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_tail_ff   <= rsp_tail_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = SLOT_PORT_W'(rsp_slot_ff);
   assign rsp_removed_value = VALUE_W'(rsp_rval_ff);
   assign rsp_head_slot     = SLOT_PORT_W'(rsp_head_ff);
   assign rsp_tail_slot     = SLOT_PORT_W'(rsp_tail_ff);
   assign rsp_entry_count   = SLOT_PORT_W'(rsp_count_ff);

   // checks
   `ASSERT_IMPLY(a_rsp_in_idle, rsp_valid_ff, upc_ff == UPC_IDLE)
   `ASSERT_NEXT(a_accept_check, accept, upc_ff == UPC_CHECK)
   `ASSERT_NOW(a_count_below_fill, (SLOT_W + 1)'(count_ff) < fill_ff)
   `ASSERT_NOW(a_empty_head, (count_ff == '0) == (first_ff == '0))

endmodule

>>> tb/alle_list_checker.sv
`timescale 1ns / 1ps

// Watches the request and result channels of the list engine, keeps its own
// copy of the link arrays and free list, and checks every result beat
// against the oldest answer still owed.
module alle_list_checker
   import alle_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic                   req_type,
   input  logic [VALUE_W-1:0]     req_value,
   input  logic [SLOT_PORT_W-1:0] req_position,
   input  logic                   rsp_valid,
   input  logic [1:0]             rsp_status,
   input  logic [SLOT_PORT_W-1:0] rsp_slot,
   input  logic [VALUE_W-1:0]     rsp_removed_value,
   input  logic [SLOT_PORT_W-1:0] rsp_head_slot,
   input  logic [SLOT_PORT_W-1:0] rsp_tail_slot,
   input  logic [SLOT_PORT_W-1:0] rsp_entry_count,
   output int                     fail_count,
   output int                     open_count
);

   localparam int SLOTS = CAPACITY_DEF;

   typedef logic [SLOT_PORT_W-1:0] slot_type;

   typedef struct {
      status_type         status;
      slot_type           slot;
      logic [VALUE_W-1:0] removed;
      slot_type           head;
      slot_type           tail;
      slot_type           count;
   } answer_type;

   // shadow list state
   logic [VALUE_W-1:0] word_mem  [SLOTS];
   slot_type           fwd_link  [SLOTS];
   slot_type           back_link [SLOTS];
   bit                 is_free   [SLOTS];
   slot_type           free_top;
   slot_type           head_q;
   slot_type           tail_q;
   slot_type           live_count;

   answer_type pending_answers [$];
   int         fails  = 0;
   int         open_n = 0;

   assign fail_count = fails;
   assign open_count = open_n;

   // one line per mismatch
   task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      fails++;
   endtask

   task automatic clear_list();
      for (int i = 0; i < SLOTS; i++) begin
         word_mem[i]  = '0;
         fwd_link[i]  = slot_type'(i + 1);
         back_link[i] = '0;
         is_free[i]   = 1'b1;
      end
      fwd_link[0]         = '0;
      fwd_link[SLOTS - 1] = '0;
      is_free[0]          = 1'b0;
      free_top            = slot_type'(1);
      head_q              = '0;
      tail_q              = '0;
      live_count          = '0;
   endtask

   // apply one request to the shadow list and work out its answer
   task automatic apply_request(input req_kind_type kind, input logic [VALUE_W-1:0] data,
                                input slot_type pos, output answer_type a);
      slot_type s;
      slot_type p;
      slot_type n;
      a.status  = ST_DONE;
      a.slot    = '0;
      a.removed = '0;
      if (kind == REQ_APPEND) begin
         s = free_top;
         if (s == '0) begin
            a.status = ST_FULL;
         end else begin
            word_mem[s]  = data;
            back_link[s] = tail_q;
            if (tail_q != '0)
               fwd_link[tail_q] = s;
            tail_q = s;
            if (live_count == '0)
               head_q = s;
            live_count  = live_count + 1'b1;
            free_top    = fwd_link[s];
            fwd_link[s] = '0;
            is_free[s]  = 1'b0;
            a.slot      = s;
         end
      end else begin
         if (pos == '0 || is_free[pos]) begin
            a.status = ST_BAD;
         end else begin
            p = back_link[pos];
            n = fwd_link[pos];
            if (p != '0)
               fwd_link[p] = n;
            if (n != '0)
               back_link[n] = p;
            a.removed = word_mem[pos];
            if (live_count != '0)
               live_count = live_count - 1'b1;
            if (head_q == pos)
               head_q = n;
            if (tail_q == pos)
               tail_q = p;
            back_link[pos] = '0;
            fwd_link[pos]  = free_top;
            free_top       = pos;
            is_free[pos]   = 1'b1;
            a.slot         = pos;
         end
      end
      a.head  = head_q;
      a.tail  = tail_q;
      a.count = live_count;
   endtask

   // result beat first (it belongs to an older request), then any new request
   always @(posedge clock) begin
      answer_type want;
      answer_type fresh;
      if (reset) begin
         clear_list();
         pending_answers.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               flag("result beat with nothing owed", 32'(rsp_slot), 32'd0);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_status != want.status)
                  flag("rsp_status", 32'(rsp_status), 32'(want.status));
               if (rsp_slot != want.slot)
                  flag("rsp_slot", 32'(rsp_slot), 32'(want.slot));
               if (rsp_removed_value != want.removed)
                  flag("rsp_removed_value", rsp_removed_value, want.removed);
               if (rsp_head_slot != want.head)
                  flag("rsp_head_slot", 32'(rsp_head_slot), 32'(want.head));
               if (rsp_tail_slot != want.tail)
                  flag("rsp_tail_slot", 32'(rsp_tail_slot), 32'(want.tail));
               if (rsp_entry_count != want.count)
                  flag("rsp_entry_count", 32'(rsp_entry_count), 32'(want.count));
            end
         end
         if (start && !busy) begin
            apply_request(req_kind_type'(req_type), req_value, req_position, fresh);
            pending_answers.push_back(fresh);
         end
      end
      open_n = pending_answers.size();
   end

endmodule

>>> tb/tb_array_linked_list_engine_core.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the list engine; all checking sits in the checker.
module tb_array_linked_list_engine_core;
   import alle_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1500;

   logic                   clock;
   logic                   reset        = 1'b1;
   logic                   start        = 1'b0;
   logic                   req_type     = 1'b0;
   logic [VALUE_W-1:0]     req_value    = '0;
   logic [SLOT_PORT_W-1:0] req_position = '0;

   logic                   busy;
   logic                   rsp_valid;
   logic [1:0]             rsp_status;
   logic [SLOT_PORT_W-1:0] rsp_slot;
   logic [VALUE_W-1:0]     rsp_removed_value;
   logic [SLOT_PORT_W-1:0] rsp_head_slot;
   logic [SLOT_PORT_W-1:0] rsp_tail_slot;
   logic [SLOT_PORT_W-1:0] rsp_entry_count;

   int fail_count;
   int open_count;
   int cycle_count = 0;
   int burst_left  = 0;
   int sent        = 0;
   int phase       = 0;

   // slots believed to be in the list, used to aim most deletes
   bit           live_map [CAPACITY_DEF];
   req_kind_type inflight_kind = REQ_APPEND;

   array_linked_list_engine_core u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_removed_value (rsp_removed_value),
      .rsp_head_slot     (rsp_head_slot),
      .rsp_tail_slot     (rsp_tail_slot),
      .rsp_entry_count   (rsp_entry_count)
   );

   alle_list_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_removed_value (rsp_removed_value),
      .rsp_head_slot     (rsp_head_slot),
      .rsp_tail_slot     (rsp_tail_slot),
      .rsp_entry_count   (rsp_entry_count),
      .fail_count        (fail_count),
      .open_count        (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   // track occupancy from the result beats; one request in flight at a time
   always @(posedge clock) begin
      if (reset) begin
         foreach (live_map[i])
            live_map[i] <= 1'b0;
      end else begin
         if (rsp_valid && rsp_status == ST_DONE)
            live_map[rsp_slot] <= (inflight_kind == REQ_APPEND);
         if (start && !busy)
            inflight_kind <= req_kind_type'(req_type);
      end
   end

   // mostly a slot in the list, now and then any position
   function automatic logic [SLOT_PORT_W-1:0] pick_target();
      int n;
      int k;
      n = 0;
      foreach (live_map[i])
         if (live_map[i])
            n++;
      if (n == 0 || $urandom_range(0, 4) == 0)
         return SLOT_PORT_W'($urandom_range(0, CAPACITY_DEF - 1));
      k = $urandom_range(0, n - 1);
      foreach (live_map[i]) begin
         if (live_map[i]) begin
            if (k == 0)
               return SLOT_PORT_W'(i);
            k--;
         end
      end
      return '0;
   endfunction

   task automatic wait_accept();
      do
         @(posedge clock);
      while (busy);
      sent++;
   endtask

   task automatic send_fixed(input req_kind_type kind, input logic [VALUE_W-1:0] data,
                             input logic [SLOT_PORT_W-1:0] pos);
      @(negedge clock);
      start        <= 1'b1;
      req_type     <= kind;
      req_value    <= data;
      req_position <= pos;
      wait_accept();
   endtask

   // choose the beat at the falling edge so occupancy is settled
   task automatic send_random(input int append_pct);
      req_kind_type       kind;
      logic [VALUE_W-1:0] data;
      @(negedge clock);
      kind = ($urandom_range(1, 100) <= append_pct) ? REQ_APPEND : REQ_DELETE;
      case ($urandom_range(0, 15))
         0:       data = '0;
         1:       data = '1;
         default: data = $urandom;
      endcase
      start        <= 1'b1;
      req_type     <= kind;
      req_value    <= data;
      req_position <= (kind == REQ_DELETE) ? pick_target()
                                           : SLOT_PORT_W'($urandom_range(0, 63));
      wait_accept();
   endtask

   task automatic hold_low(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // bursts of random length, random gaps between them
   task automatic idle_between();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         hold_low($urandom_range(1, 10));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
      end
   endtask

   // sender stands off until every owed result has come back
   task automatic drain_wait();
      @(negedge clock);
      start <= 1'b0;
      while (open_count != 0)
         @(negedge clock);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin
      int span;
      int pct;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: value extremes, bad deletes, head, middle and tail unlink,
      // emptying the list and reuse of a freed slot
      send_fixed(REQ_APPEND, 32'h0000_0000, 6'd0);
      send_fixed(REQ_APPEND, 32'hFFFF_FFFF, 6'd63);
      send_fixed(REQ_APPEND, 32'h5555_5555, 6'd21);
      send_fixed(REQ_APPEND, 32'hAAAA_AAAA, 6'd42);
      send_fixed(REQ_DELETE, 32'hFFFF_FFFF, 6'd0);
      send_fixed(REQ_DELETE, 32'h0, 6'd63);
      send_fixed(REQ_DELETE, 32'h0, 6'd2);
      send_fixed(REQ_DELETE, 32'h0, 6'd2);
      send_fixed(REQ_DELETE, 32'h0, 6'd1);
      hold_low(3);
      send_fixed(REQ_DELETE, 32'h0, 6'd4);
      send_fixed(REQ_APPEND, 32'h1234_5678, 6'd0);
      send_fixed(REQ_DELETE, 32'h0, 6'd3);
      send_fixed(REQ_DELETE, 32'h0, 6'd4);
      send_fixed(REQ_DELETE, 32'h0, 6'd4);
      send_fixed(REQ_APPEND, 32'h8000_0001, 6'd0);
      send_fixed(REQ_APPEND, 32'h7FFF_FFFE, 6'd0);
      send_fixed(REQ_DELETE, 32'h0, 6'd42);
      send_fixed(REQ_DELETE, 32'h0, 6'd21);
      drain_wait();

      // random phases: fill to full, drain to empty, balanced churn
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase % 3)
            0:       pct = 90;
            1:       pct = 12;
            default: pct = 50;
         endcase
         span = $urandom_range(100, 200);
         repeat (span) begin
            idle_between();
            send_random(pct);
         end
         drain_wait();
         phase++;
      end

      drain_wait();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/alle_pkg.sv
sv/alle_ram.sv
sv/array_linked_list_engine_core.sv
tb/alle_list_checker.sv
tb/tb_array_linked_list_engine_core.sv
